FILE: hdl/dvdif_pkg.sv
// ----------------------------------------------------------------------------
// dvdif_pkg
// Shared types and constants of the DV DIF frame assembler.
// ----------------------------------------------------------------------------
package dvdif_pkg;

  localparam int unsigned OFF_W      = 18;
  localparam int unsigned CALC_W     = 20;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned PERIOD_W   = 17;
  localparam int unsigned IDX_W      = 2;
  localparam int unsigned IN_W       = 48;
  localparam int unsigned OUT_W      = 56;

  localparam logic [CALC_W-1:0] PAL_BYTES   = 20'd144000;
  localparam logic [CALC_W-1:0] NTSC_BYTES  = 20'd120000;
  localparam logic [CALC_W-1:0] BLOCK_BYTES = 20'd80;
  localparam logic [CALC_W-1:0] SEQ_BYTES   = 20'd12000;
  localparam logic [CALC_W-1:0] PKT_BYTES   = 20'd480;
  localparam logic [15:0]       MIN_LEN     = 16'd16;
  localparam logic [OFF_W-1:0]  CNT_MAX     = 18'd262143;

  // blk / 15 for an 8-bit blk: (blk * 137) >> 11
  localparam logic [7:0]  DIV15_MUL   = 8'd137;
  localparam int unsigned DIV15_SHIFT = 11;

  localparam logic [IDX_W-1:0] REG_DROP_SHORT  = 2'd0;
  localparam logic [IDX_W-1:0] REG_SKIP_FRAMES = 2'd1;
  localparam logic [IDX_W-1:0] REG_KEEP_FRAMES = 2'd2;

  localparam logic [2:0] SECT_HEADER = 3'd0;
  localparam logic [2:0] SECT_SUBCODE = 3'd1;
  localparam logic [2:0] SECT_VAUX   = 3'd2;
  localparam logic [2:0] SECT_AUDIO  = 3'd3;
  localparam logic [2:0] SECT_VIDEO  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLACE,
    ST_DIV,
    ST_EVAL,
    ST_OUT
  } state_t;

endpackage

FILE: hdl/dv_dif_frame_assembler.sv
// ----------------------------------------------------------------------------
// dv_dif_frame_assembler
// Decodes DV packet headers, tracks frames, decimates and gives buffer offsets.
// ----------------------------------------------------------------------------
//  channel   dir  fields
//  s_axis    in   tdata: packet_length[15:0], dif_header[47:16]
//  m_axis    out  tdata: write_enable, write_offset, frame_start, frame_number,
//                        frame_ready, frame_discard, format_pal, offset_overflow
//  cfg       in   cfg_write, cfg_index, cfg_data
//
//  An accepted item passes through the decode, evaluate and output states
//  before its result can be taken; a frame header with keep_frames
//  nonzero also passes through the one-bit-per-cycle restoring modulo
//  unit, which finds the decimation phase.
//  One item at a time: s_axis_tready is high only while idle, and the next
//  item is taken the cycle after the result leaves. rst is synchronous.
module dv_dif_frame_assembler (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [15:0] packet_length, [47:16] dif_header
  input  logic [dvdif_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] write_enable, [18:1] write_offset, [19] frame_start,
  // [51:20] frame_number, [52] frame_ready, [53] frame_discard,
  // [54] format_pal, [55] offset_overflow
  output logic [dvdif_pkg::OUT_W-1:0]   m_axis_tdata,
  input  logic                          cfg_write,
  input  logic [dvdif_pkg::IDX_W-1:0]   cfg_index,
  input  logic [15:0]                   cfg_data
);
  import dvdif_pkg::*;

  state_t state, state_next;

  logic                drop_short;
  logic [15:0]         skip_frames;
  logic [15:0]         keep_frames;

  logic                format_known;
  logic                is_pal;
  logic                frame_open;
  logic [OFF_W-1:0]    bytes_received;
  logic [CNT_W-1:0]    frame_counter;

  logic [15:0]         len_q;
  logic [31:0]         hdr_q;
  logic [CALC_W-1:0]   off_q;
  logic                placeable;

  logic [PERIOD_W-1:0] rem;
  logic [CNT_W-1:0]    dvd;
  logic [4:0]          step;

  logic [OUT_W-1:0]    out_data;

  // header decode
  logic [2:0]  sect;
  logic [3:0]  seq;
  logic [7:0]  blk;
  logic        pal_bit;
  logic        long_pkt;
  logic        is_hdr;

  assign sect     = hdr_q[31:29];
  assign seq      = hdr_q[23:20];
  assign blk      = hdr_q[15:8];
  assign pal_bit  = hdr_q[7];
  assign long_pkt = len_q > MIN_LEN;
  assign is_hdr   = long_pkt && (sect == SECT_HEADER) && (seq == 4'd0);

  // block index within a sequence
  logic [15:0]       blk_mul;
  logic [11:0]       blk_idx;
  logic [CALC_W-1:0] off_calc;

  assign blk_mul = 16'(blk) * 16'(DIV15_MUL);

  always_comb begin
    blk_idx = '0;
    case (sect)
      SECT_HEADER:  blk_idx = '0;
      SECT_SUBCODE: blk_idx = 12'd1 + 12'(blk);
      SECT_VAUX:    blk_idx = 12'd3 + 12'(blk);
      SECT_AUDIO:   blk_idx = 12'd6 + {blk, 4'd0};
      SECT_VIDEO:   blk_idx = 12'd7 + 12'(blk_mul >> DIV15_SHIFT) + 12'(blk);
      default:      blk_idx = '0;
    endcase
  end

  assign off_calc = CALC_W'(seq) * SEQ_BYTES + CALC_W'(blk_idx) * BLOCK_BYTES;

  // modulo step
  logic [PERIOD_W-1:0] period;
  logic [PERIOD_W:0]   rem_sh;
  logic                rem_ge;

  assign period = PERIOD_W'(skip_frames) + PERIOD_W'(keep_frames);
  assign rem_sh = {rem, dvd[CNT_W-1]};
  assign rem_ge = rem_sh >= {1'b0, period};

  // result evaluation
  logic              pal_eff;
  logic [CALC_W-1:0] fsize;
  logic              open_new;
  logic              open_eff;
  logic              ovf;
  logic              wen;
  logic              fready;
  logic              fdrop;
  logic [OFF_W-1:0]  bytes_base;
  logic [OFF_W:0]    bytes_sum;
  logic [OFF_W-1:0]  bytes_upd;

  always_comb begin
    pal_eff   = (is_hdr && !format_known) ? pal_bit : is_pal;
    fsize     = pal_eff ? PAL_BYTES : NTSC_BYTES;
    open_new  = (keep_frames != 16'd0) && (rem < PERIOD_W'(keep_frames));
    open_eff  = is_hdr ? open_new : frame_open;
    ovf       = long_pkt && open_eff && placeable && ((off_q + PKT_BYTES) > fsize);
    wen       = long_pkt && open_eff && placeable && !ovf;
    fready    = is_hdr && frame_open &&
                (!drop_short || (CALC_W'(bytes_received) == fsize));
    fdrop     = is_hdr && frame_open && !fready;
    bytes_base = is_hdr ? '0 : bytes_received;
    bytes_sum  = (OFF_W+1)'(bytes_base) + (OFF_W+1)'(PKT_BYTES);
    bytes_upd  = bytes_sum[OFF_W] ? CNT_MAX : bytes_sum[OFF_W-1:0];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_next = ST_PLACE;
      end
      ST_PLACE: begin
        state_next = (is_hdr && keep_frames != 16'd0) ? ST_DIV : ST_EVAL;
      end
      ST_DIV: begin
        if (step == 5'd31) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      drop_short  <= 1'b1;
      skip_frames <= '0;
      keep_frames <= 16'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DROP_SHORT:  drop_short  <= cfg_data[0];
        REG_SKIP_FRAMES: skip_frames <= cfg_data;
        REG_KEEP_FRAMES: keep_frames <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      format_known   <= 1'b0;
      is_pal         <= 1'b0;
      frame_open     <= 1'b0;
      bytes_received <= '0;
      frame_counter  <= '0;
    end else if (state == ST_EVAL && long_pkt) begin
      if (is_hdr) begin
        format_known  <= 1'b1;
        is_pal        <= pal_eff;
        frame_open    <= open_new;
        frame_counter <= frame_counter + CNT_W'(1);
      end
      if (open_eff) begin
        bytes_received <= bytes_upd;
      end else if (is_hdr) begin
        bytes_received <= '0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          len_q <= s_axis_tdata[15:0];
          hdr_q <= s_axis_tdata[47:16];
        end
      end
      ST_PLACE: begin
        off_q     <= off_calc;
        placeable <= sect <= SECT_VIDEO;
        rem       <= '0;
        dvd       <= frame_counter + CNT_W'(1);
        step      <= '0;
      end
      ST_DIV: begin
        rem  <= rem_ge ? PERIOD_W'(rem_sh - {1'b0, period}) : rem_sh[PERIOD_W-1:0];
        dvd  <= {dvd[CNT_W-2:0], 1'b0};
        step <= step + 5'd1;
      end
      ST_EVAL: begin
        out_data[0]     <= wen;
        out_data[18:1]  <= wen ? off_q[OFF_W-1:0] : '0;
        out_data[19]    <= is_hdr && open_new;
        out_data[51:20] <= (is_hdr && open_new) ? frame_counter : '0;
        out_data[52]    <= fready;
        out_data[53]    <= fdrop;
        out_data[54]    <= long_pkt ? pal_eff : is_pal;
        out_data[55]    <= ovf;
      end
      default: ;
    endcase
  end

  assign m_axis_tdata = out_data;

endmodule

FILE: hdl/dvdif_checker.sv
// ----------------------------------------------------------------------------
// dvdif_checker
// Port-level checks of the DV DIF frame assembler, bound to the top level.
// ----------------------------------------------------------------------------
module dvdif_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [dvdif_pkg::OUT_W-1:0] m_axis_tdata
);

  // one item in flight: no new item while a result waits
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready && !m_axis_tvalid)
    else $error("block not busy after an item was taken");

  a_write_xor_ovf: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[55]) &&
                      !(m_axis_tdata[52] && m_axis_tdata[53]))
    else $error("conflicting result flags");

  a_offset_needs_write: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[18:1] == '0))
    else $error("offset given without write");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind dv_dif_frame_assembler dvdif_checker u_dvdif_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: dv/dv_dif_frame_assembler_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dv_dif_frame_assembler_test
// Self-checking bench for the DV DIF frame assembler. Each packet item is fed
// through a local model of the frame tracker (format detection, frame
// close and decimation, byte offsets, overflow and byte counting). Every
// output item is compared field by field with the oldest predicted
// placement. Stimulus is a short directed decode pass, then well-formed
// frames with random content mixed with truncated, overlong and mid-frame
// runs and noise, under several decimation and drop settings. Both stream
// sides idle at random.
// ----------------------------------------------------------------------------
module dv_dif_frame_assembler_test;
  import dvdif_pkg::*;

  localparam int unsigned PAL_FRAME_BYTES  = 144000;
  localparam int unsigned NTSC_FRAME_BYTES = 120000;
  localparam int unsigned DIF_BLOCK_BYTES  = 80;
  localparam int unsigned SEQ_SPAN         = 150 * DIF_BLOCK_BYTES;
  localparam int unsigned PACKET_BYTES     = 480;
  localparam int unsigned PACKET_BLOCKS    = 6;
  localparam int unsigned SEQ_PACKETS      = 25;
  localparam int unsigned AUDIO_PERIOD     = 16;
  localparam int unsigned BYTE_COUNT_MAX   = 262143;
  localparam int unsigned SHORT_LEN        = 16;
  localparam logic [15:0] DATA_LEN         = 16'd488;
  localparam int unsigned DRAIN_LIMIT      = 20000;

  // same bit layout as m_axis_tdata, lowest field last
  typedef struct packed {
    logic        overflow;
    logic        pal;
    logic        dropped;
    logic        ready;
    logic [31:0] number;
    logic        start;
    logic [17:0] offset;
    logic        wen;
  } placement_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  // [15:0] packet_length, [47:16] dif_header
  logic [IN_W-1:0]    s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  // [0] write_enable, [18:1] write_offset, [19] frame_start,
  // [51:20] frame_number, [52] frame_ready, [53] frame_discard,
  // [54] format_pal, [55] offset_overflow
  logic [OUT_W-1:0]   m_axis_tdata;
  logic               cfg_write = 1'b0;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  // tracker model state, reset values
  logic        drop_partial = 1'b1;
  logic [15:0] skip_count = 16'd0;
  logic [15:0] keep_count = 16'd1;
  logic        fmt_known = 1'b0;
  logic        fmt_pal = 1'b0;
  logic        frame_open = 1'b0;
  logic [17:0] frame_byte_count = '0;
  logic [31:0] frames_seen = '0;

  placement_t  placements_due[$];
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned errors = 0;
  int unsigned burst_left = 0;
  logic [5:0]  rx_tick = '0;
  logic [1:0]  rx_mode = '0;

  dv_dif_frame_assembler i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int unsigned frame_bytes();
    return fmt_pal ? PAL_FRAME_BYTES : NTSC_FRAME_BYTES;
  endfunction

  function automatic placement_t place_packet(input logic [15:0] len,
                                              input logic [31:0] hdr);
    placement_t  res;
    logic [2:0]  sect;
    logic [3:0]  seq;
    int unsigned blk, base, off, period;
    logic [31:0] nxt;
    logic        stored;
    res = '0;
    off = 0;
    if (len > SHORT_LEN) begin
      sect = hdr[31:29];
      seq  = hdr[23:20];
      blk  = 32'(hdr[15:8]);
      if (sect == SECT_HEADER && seq == 4'd0) begin
        if (!fmt_known) begin
          fmt_known = 1'b1;
          fmt_pal   = hdr[7];
        end
        if (frame_open) begin
          if (!drop_partial || frame_byte_count == frame_bytes()) begin
            res.ready = 1'b1;
          end else begin
            res.dropped = 1'b1;
          end
        end
        frame_open = 1'b0;
        nxt    = frames_seen + 32'd1;
        period = 32'(skip_count) + 32'(keep_count);
        if (keep_count != 0 && period != 0 && (nxt % period) < keep_count) begin
          frame_open = 1'b1;
          res.start  = 1'b1;
          res.number = frames_seen;
        end
        frames_seen      = nxt;
        frame_byte_count = '0;
      end
      if (frame_open) begin
        base   = seq * SEQ_SPAN;
        stored = 1'b1;
        case (sect)
          SECT_HEADER:  off = base;
          SECT_SUBCODE: off = base + (1 + blk) * DIF_BLOCK_BYTES;
          SECT_VAUX:    off = base + (3 + blk) * DIF_BLOCK_BYTES;
          SECT_AUDIO:   off = base + (6 + blk * 16) * DIF_BLOCK_BYTES;
          SECT_VIDEO:   off = base + (7 + blk / 15 + blk) * DIF_BLOCK_BYTES;
          default:      stored = 1'b0;
        endcase
        if (stored) begin
          if (off + PACKET_BYTES > frame_bytes()) begin
            res.overflow = 1'b1;
          end else begin
            res.wen    = 1'b1;
            res.offset = off[17:0];
          end
        end
        if (frame_byte_count + PACKET_BYTES > BYTE_COUNT_MAX) begin
          frame_byte_count = 18'(BYTE_COUNT_MAX);
        end else begin
          frame_byte_count = 18'(frame_byte_count + PACKET_BYTES);
        end
      end
    end
    res.pal = fmt_pal;
    return res;
  endfunction

  // random DIF header bytes with the section, sequence and block fields forced
  function automatic logic [31:0] dif_word(input logic [2:0] sect, input logic [3:0] seq,
                                           input logic [7:0] blk);
    logic [31:0] w;
    w         = $urandom;
    w[31:29]  = sect;
    w[23:20]  = seq;
    w[15:8]   = blk;
    return w;
  endfunction

  // first block header of packet idx in a well-formed frame
  function automatic logic [31:0] stream_word(input int unsigned idx);
    int unsigned pos, j;
    logic [31:0] w;
    pos = (idx % SEQ_PACKETS) * PACKET_BLOCKS;
    if (pos == 0) begin
      w    = dif_word(SECT_HEADER, 4'(idx / SEQ_PACKETS), 8'd0);
      w[7] = fmt_pal;
    end else begin
      j = pos - PACKET_BLOCKS;
      if (j % AUDIO_PERIOD == 0) begin
        w = dif_word(SECT_AUDIO, 4'(idx / SEQ_PACKETS), 8'(j / AUDIO_PERIOD));
      end else begin
        w = dif_word(SECT_VIDEO, 4'(idx / SEQ_PACKETS),
                     8'((j / AUDIO_PERIOD) * 15 + j % AUDIO_PERIOD - 1));
      end
    end
    return w;
  endfunction

  function automatic logic [31:0] body_word();
    logic [31:0] w;
    w = $urandom;
    if (w[31:29] == SECT_HEADER && w[23:20] == 4'd0) w[23:20] = 4'($urandom_range(1, 15));
    return w;
  endfunction

  function automatic logic [15:0] data_len();
    if ($urandom_range(0, 3) != 0) return DATA_LEN;
    return 16'($urandom_range(SHORT_LEN + 1, 65535));
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      flag_error($sformatf("result %0d: %s expected 0x%0h, got 0x%0h",
                           results_checked, name, want, got));
    end
  endtask

  task automatic send_packet(input logic [15:0] len, input logic [31:0] hdr);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      case ($urandom_range(0, 7))
        0, 1:       gap = 0;
        2, 3, 4, 5: gap = $urandom_range(1, 3);
        6:          gap = $urandom_range(4, 12);
        default:    gap = $urandom_range(13, 45);
      endcase
    end
    burst_left--;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= {hdr, len};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    placements_due.push_back(place_packet(len, hdr));
    if (len > SHORT_LEN) items_sent++;
  endtask

  task automatic send_stream(input int unsigned first, input int unsigned count);
    for (int unsigned i = first; i < first + count; i++) begin
      send_packet(data_len(), stream_word(i));
    end
  endtask

  task automatic wait_idle();
    int unsigned waited;
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (placements_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic drop, input logic [15:0] skip,
                            input logic [15:0] keep);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= REG_DROP_SHORT;
    cfg_data  <= {15'd0, drop};
    @(posedge clk);
    cfg_index <= REG_SKIP_FRAMES;
    cfg_data  <= skip;
    @(posedge clk);
    cfg_index <= REG_KEEP_FRAMES;
    cfg_data  <= keep;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    drop_partial = drop;
    skip_count   = skip;
    keep_count   = keep;
  endtask

  // one random run: full, truncated or overlong frame, noise, or mid-frame packets
  task automatic send_random_run(input logic allow_full, input int unsigned max_body);
    int unsigned pick, full, n;
    logic [15:0] len;
    pick = $urandom_range(0, 9);
    if (!allow_full && pick < 3) pick = $urandom_range(3, 5);
    full = frame_bytes() / PACKET_BYTES;
    case (pick)
      0, 1, 2: send_stream(0, full);
      3, 4, 5: send_stream(0, $urandom_range(1, max_body));
      6: begin
        send_stream(0, allow_full ? full : $urandom_range(1, max_body));
        repeat ($urandom_range(1, 3)) send_packet(data_len(), body_word());
      end
      7, 8: begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          case ($urandom_range(0, 7))
            0, 1:    len = 16'($urandom_range(0, SHORT_LEN));
            2:       len = $urandom_range(0, 1) ? 16'hFFFF : 16'(SHORT_LEN + 1);
            default: len = 16'($urandom);
          endcase
          send_packet(len, $urandom);
        end
      end
      default: send_stream($urandom_range(1, full - 1), $urandom_range(1, 20));
    endcase
  endtask

  task automatic test_packet_decode();
    logic fmt;
    fmt = 1'($urandom_range(0, 1));
    send_packet(16'd0, $urandom);
    send_packet(16'(SHORT_LEN), 32'h0000_0000);
    send_packet(16'(SHORT_LEN + 1), dif_word(SECT_SUBCODE, 4'd0, 8'd1));
    send_packet(16'hFFFF, {3'b000, 5'h1F, 4'h0, 4'hF, 8'hFF, fmt, 7'h7F});
    send_packet(DATA_LEN, dif_word(SECT_SUBCODE, 4'd0, 8'd1));
    send_packet(DATA_LEN, dif_word(SECT_VAUX, 4'd3, 8'd2));
    send_packet(DATA_LEN, dif_word(SECT_AUDIO, 4'd9, 8'd255));
    send_packet(DATA_LEN, dif_word(SECT_AUDIO, 4'd1, 8'd8));
    send_packet(DATA_LEN, dif_word(SECT_VIDEO, 4'd2, 8'd134));
    send_packet(DATA_LEN, dif_word(SECT_VIDEO, 4'd0, 8'd255));
    for (int unsigned s = 5; s < 8; s++) send_packet(DATA_LEN, dif_word(3'(s), 4'd4, 8'd7));
    send_packet(DATA_LEN, dif_word(SECT_HEADER, 4'd7, 8'd0));
    send_packet(DATA_LEN, dif_word(SECT_HEADER, 4'd15, 8'd0));
    send_packet(DATA_LEN, dif_word(SECT_SUBCODE, 4'd9, 8'd255));
    send_packet(16'hFFFF, 32'hFFFF_FFFF);
    send_packet(16'(SHORT_LEN), dif_word(SECT_HEADER, 4'd0, 8'd0));
    // header with the other format bit: format stays, open frame is dropped
    send_packet(16'h8000, {3'b000, 5'h00, 4'h0, 4'h0, 8'h00, ~fmt, 7'h00});
    send_packet(DATA_LEN, dif_word(SECT_VIDEO, 4'd4, 8'd0));
  endtask

  task automatic test_frame_completion();
    int unsigned run_end;
    set_config(1'b1, 16'd0, 16'd1);
    // overlong frame: byte count saturates, next header drops it
    send_packet(data_len(), stream_word(0));
    repeat ($urandom_range(547, 570)) send_packet(data_len(), body_word());
    run_end = items_sent + 250;
    while (items_sent < run_end) send_random_run(1'b1, 40);
    set_config(1'b0, 16'd0, 16'd1);
    run_end = items_sent + 100;
    while (items_sent < run_end) send_random_run(1'b1, 40);
  endtask

  task automatic test_decimation();
    int unsigned run_end;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       set_config(1'b0, 16'd2, 16'd1);
        1:       set_config(1'b1, 16'd1, 16'd3);
        2:       set_config(1'b0, 16'd0, 16'd0);
        3:       set_config(1'b1, 16'hFFFF, 16'hFFFF);
        4:       set_config(1'b0, 16'hFFFF, 16'd1);
        5:       set_config(1'b1, 16'd3, 16'd2);
        default: set_config(1'($urandom_range(0, 1)), 16'($urandom_range(0, 4)),
                            16'($urandom_range(1, 4)));
      endcase
      run_end = items_sent + 75;
      while (items_sent < run_end) send_random_run(1'b0, 6);
    end
  endtask

  always @(posedge clk) begin
    if (rx_tick == 6'd0) rx_mode <= 2'($urandom_range(0, 3));
    rx_tick <= rx_tick + 6'd1;
    case (rx_mode)
      2'd0:    m_axis_tready <= 1'b1;
      2'd1:    m_axis_tready <= 1'($urandom_range(0, 1));
      2'd2:    m_axis_tready <= (rx_tick[1:0] == 2'd0);
      default: m_axis_tready <= (rx_tick[5:3] == 3'd0);
    endcase
  end

  always @(posedge clk) begin : result_check
    placement_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (placements_due.size() == 0) begin
        flag_error($sformatf("unexpected result 0x%0h", m_axis_tdata));
      end else begin
        want = placements_due.pop_front();
        check_field("write_enable", 32'(want.wen), 32'(got.wen));
        check_field("write_offset", 32'(want.offset), 32'(got.offset));
        check_field("frame_start", 32'(want.start), 32'(got.start));
        check_field("frame_number", want.number, got.number);
        check_field("frame_ready", 32'(want.ready), 32'(got.ready));
        check_field("frame_discard", 32'(want.dropped), 32'(got.dropped));
        check_field("format_pal", 32'(want.pal), 32'(got.pal));
        check_field("offset_overflow", 32'(want.overflow), 32'(got.overflow));
      end
      results_checked++;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_packet_decode();
    test_frame_completion();
    test_decimation();
    wait_idle();
    repeat (40) @(posedge clk);
    if (placements_due.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", placements_due.size()));
    end
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/dvdif_pkg.sv
hdl/dv_dif_frame_assembler.sv
hdl/dvdif_checker.sv
dv/dv_dif_frame_assembler_test.sv
